// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and arithmetic helpers of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int BUFFER_DEPTH_DEF = 65536;
	localparam int SAMPLE_W         = 16;
	localparam int DELAY_W          = 16;
	localparam int FB_GAIN_W        = 15;
	localparam int DRY_W            = 16;
	localparam int DELAY_RESET      = 24000;
	localparam int FB_GAIN_RESET    = 16384;
	localparam int DRY_RESET        = 16384;
	localparam int UNITY            = 32768;
	localparam int OUT_DEPTH        = 4;
	localparam int ARITH_W          = 36;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DELAY   = 2'd0;
	localparam logic [1:0] REG_FB_GAIN = 2'd1;
	localparam logic [1:0] REG_DRY     = 2'd2;

	// per-item flags of the write/read stage
	typedef struct packed {
		logic valid;
		logic rd_ok;   // read entry was written since reset
		logic rd_same; // read entry is the one written by this item
	} lane_ctl_t;

	typedef struct packed {
		logic [FB_GAIN_W-1:0] fb_gain;
		logic [DRY_W-1:0]     dry;
		logic [DRY_W-1:0]     wet;
	} gain_cfg_t;

	// add one half, floor-divide by 2^15
	function automatic logic signed [ARITH_W-1:0] round_q15(
		input logic signed [ARITH_W-1:0] p
	);
		return (p + ARITH_W'(signed'(16384))) >>> 15;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat16(
		input logic signed [ARITH_W-1:0] v
	);
		logic signed [SAMPLE_W-1:0] r;
		if (v > ARITH_W'(signed'(32767))) begin
			r = 16'sh7fff;
		end else if (v < -ARITH_W'(signed'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/sfd_delay_mod.sv =====
// ----------------------------------------------------------------------------
// sfd_delay_mod
// Remainder of the delay register by the buffer depth, by reciprocal
// multiplication: a quotient step, then a remainder step.
// ----------------------------------------------------------------------------
module sfd_delay_mod #(
	parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sfd_pkg::DELAY_W-1:0]       value,
	output logic                              busy,
	output logic [$clog2(BUFFER_DEPTH)-1:0]   rem
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int SH = sfd_pkg::DELAY_W + AW;
	localparam int MW = sfd_pkg::DELAY_W + 2;
	localparam int PW = sfd_pkg::DELAY_W + MW;
	localparam longint RECIP_L = ((longint'(1) << SH) + longint'(BUFFER_DEPTH) - 1)
		/ longint'(BUFFER_DEPTH);
	localparam logic [MW-1:0] RECIP     = MW'(RECIP_L);
	localparam logic [sfd_pkg::DELAY_W-1:0] DEPTH_LO = sfd_pkg::DELAY_W'(BUFFER_DEPTH);
	localparam logic [AW-1:0] RESET_REM = AW'(sfd_pkg::DELAY_RESET % BUFFER_DEPTH);
	localparam logic [1:0]    STEPS     = 2'd2;

	logic [sfd_pkg::DELAY_W-1:0] src_q;
	logic [sfd_pkg::DELAY_W-1:0] q_q;
	logic [AW-1:0]               rem_q;
	logic [1:0]                  cnt_q;
	logic [PW-1:0]               prod;
	logic [sfd_pkg::DELAY_W-1:0] qd;

	// quotient is exact for any 16-bit value with a shift of 16 + log2(depth)
	always_comb begin
		prod = PW'(src_q) * PW'(RECIP);
		qd   = q_q * DEPTH_LO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
			q_q   <= '0;
			rem_q <= RESET_REM;
			cnt_q <= '0;
		end else if (start) begin
			src_q <= value;
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			if (cnt_q == STEPS) begin
				q_q <= sfd_pkg::DELAY_W'(prod >> SH);
			end else begin
				rem_q <= AW'(src_q - qd);
			end
			cnt_q <= cnt_q - 2'd1;
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

endmodule

// ===== rtl/sfd_lane.sv =====
// ----------------------------------------------------------------------------
// sfd_lane
// One channel: delay memory write/read, feedback loop and dry/wet mix.
// ----------------------------------------------------------------------------
module sfd_lane #(
	parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfd_pkg::lane_ctl_t                  ctl_s1,
	input  logic [$clog2(BUFFER_DEPTH)-1:0]     wr_addr_s1,
	input  logic [$clog2(BUFFER_DEPTH)-1:0]     rd_addr_s1,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0] x_s1,
	input  sfd_pkg::gain_cfg_t                  gains,
	output logic                                y_valid,
	output logic signed [sfd_pkg::SAMPLE_W-1:0] y
);

	localparam int AW = sfd_pkg::ARITH_W;

	logic signed [sfd_pkg::SAMPLE_W-1:0] mem [BUFFER_DEPTH];
	logic signed [sfd_pkg::SAMPLE_W-1:0] rdata_q;

	// feedback product of the previous item
	logic signed [31:0] fbp_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] fb;
	logic signed [sfd_pkg::SAMPLE_W-1:0] wdata;

	logic                                 v_s2, ok_s2, same_s2;
	logic signed [sfd_pkg::SAMPLE_W-1:0]  wd_s2, x_s2;
	logic signed [sfd_pkg::SAMPLE_W-1:0]  delayed;
	logic signed [sfd_pkg::SAMPLE_W:0]    fbg_s, dry_s, wet_s;

	logic                                 v_s3;
	logic signed [32:0]                   pd_s3, pw_s3;
	logic signed [AW-1:0]                 mix;

	always_comb begin
		fb    = sfd_pkg::sat16(sfd_pkg::round_q15(AW'(fbp_q)));
		wdata = sfd_pkg::sat16(AW'(x_s1) + AW'(fb));
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			mem[wr_addr_s1] <= wdata;
		end
		rdata_q <= mem[rd_addr_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			ok_s2   <= 1'b0;
			same_s2 <= 1'b0;
		end else begin
			v_s2    <= ctl_s1.valid;
			ok_s2   <= ctl_s1.rd_ok;
			same_s2 <= ctl_s1.rd_same;
		end
	end

	always_ff @(posedge clk) begin
		wd_s2 <= wdata;
		x_s2  <= x_s1;
	end

	// zero delay reads back this item's own write; unwritten entries read zero
	always_comb begin
		if (same_s2) begin
			delayed = wd_s2;
		end else if (ok_s2) begin
			delayed = rdata_q;
		end else begin
			delayed = '0;
		end
		fbg_s = signed'({2'b00, gains.fb_gain});
		dry_s = signed'({1'b0, gains.dry});
		wet_s = signed'({1'b0, gains.wet});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbp_q <= '0;
			v_s3  <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			if (v_s2) begin
				fbp_q <= delayed * fbg_s;
			end
		end
	end

	always_ff @(posedge clk) begin
		pd_s3 <= x_s2 * dry_s;
		pw_s3 <= delayed * wet_s;
	end

	assign mix     = AW'(pd_s3) + AW'(pw_s3);
	assign y       = sfd_pkg::sat16(sfd_pkg::round_q15(mix));
	assign y_valid = v_s3;

endmodule

// ===== rtl/sfd_merge.sv =====
// ----------------------------------------------------------------------------
// sfd_merge
// Joins the two lane results into one stereo word and queues it for output.
// ----------------------------------------------------------------------------
module sfd_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                left_valid,
	input  logic                                right_valid,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0] left,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0] right,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [2*sfd_pkg::SAMPLE_W-1:0]      m_tdata
);

	localparam int PW = $clog2(sfd_pkg::OUT_DEPTH);
	localparam int CW = $clog2(sfd_pkg::OUT_DEPTH + 1);

	logic [2*sfd_pkg::SAMPLE_W-1:0] buf_q [sfd_pkg::OUT_DEPTH];
	logic [PW-1:0]                  wptr_q, rptr_q;
	logic [CW-1:0]                  cnt_q;
	logic                           wr, rd;

	// room is guaranteed by the credit count in the top level
	assign wr = left_valid & right_valid;
	assign rd = m_tvalid & m_tready;

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wptr_q] <= {right, left};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = buf_q[rptr_q];

endmodule

// ===== rtl/stereo_feedback_delay_top.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top
// Stereo echo: two delay lanes with feedback and a dry/wet mix.
// ----------------------------------------------------------------------------
//  channel  dir  signals                        content
//  s_*      in   tvalid tready tdata[31:0]      left_in, right_in
//  m_*      out  tvalid tready tdata[31:0]      left_out, right_out
//  apb      in   psel penable pwrite paddr[3:0] delay, feedback gain, dry gain
//
//  A new stereo pair is not accepted while the last one is in the s1 stage;
//  the loop through the memory read, the feedback multiply and the next write sets that limit.
//  A result passes the s1, s2 and s3 registers and the output queue before it shows on m_tvalid.
//  A write of delay_samples holds s_tready low while its remainder by depth is worked out.
//  Reset needs no clearing pass: entries not yet written since reset read 0.
//  Up to 4 results queue at the output; s_tready drops while 4 pairs are in flight.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_top #(
	parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] left_in, [31:16] right_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(sfd_pkg::OUT_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(BUFFER_DEPTH);
	localparam logic [AW-1:0] WP_LAST = AW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] CREDITS = CW'(sfd_pkg::OUT_DEPTH);
	localparam logic [sfd_pkg::DRY_W-1:0] UNITY_G = sfd_pkg::DRY_W'(sfd_pkg::UNITY);

	// configuration
	logic [sfd_pkg::DELAY_W-1:0]   delay_q;
	logic [sfd_pkg::FB_GAIN_W-1:0] fbg_q;
	logic [sfd_pkg::DRY_W-1:0]     dry_q;
	logic                          wr_en;
	logic [1:0]                    reg_idx;
	sfd_pkg::gain_cfg_t            gains;

	logic                          mod_busy;
	logic [AW-1:0]                 delay_mod;

	logic [AW-1:0]                 wp_q;
	logic                          wrapped_q;
	logic [AW:0]                   rd_ext;
	logic [AW-1:0]                 rd;
	logic                          s_acc, m_acc;
	logic [CW-1:0]                 inflight_q;

	sfd_pkg::lane_ctl_t            ctl_s1;
	logic [AW-1:0]                 wa_s1, ra_s1;
	logic signed [15:0]            left_s1, right_s1;

	logic                          l_valid, r_valid;
	logic signed [15:0]            l_out, r_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= sfd_pkg::DELAY_W'(sfd_pkg::DELAY_RESET);
			fbg_q   <= sfd_pkg::FB_GAIN_W'(sfd_pkg::FB_GAIN_RESET);
			dry_q   <= sfd_pkg::DRY_W'(sfd_pkg::DRY_RESET);
		end else if (wr_en) begin
			case (reg_idx)
				sfd_pkg::REG_DELAY:   delay_q <= pwdata[sfd_pkg::DELAY_W-1:0];
				sfd_pkg::REG_FB_GAIN: fbg_q   <= pwdata[sfd_pkg::FB_GAIN_W-1:0];
				sfd_pkg::REG_DRY:     dry_q   <= pwdata[sfd_pkg::DRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sfd_pkg::REG_DELAY:   prdata = 32'(delay_q);
			sfd_pkg::REG_FB_GAIN: prdata = 32'(fbg_q);
			sfd_pkg::REG_DRY:     prdata = 32'(dry_q);
			default:              prdata = '0;
		endcase
	end

	// dry gain above unity clamps to unity
	always_comb begin
		gains.fb_gain = fbg_q;
		gains.dry     = (dry_q > UNITY_G) ? UNITY_G : dry_q;
		gains.wet     = UNITY_G - gains.dry;
	end

	sfd_delay_mod #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (wr_en && (reg_idx == sfd_pkg::REG_DELAY)),
		.value (pwdata[sfd_pkg::DELAY_W-1:0]),
		.busy  (mod_busy),
		.rem   (delay_mod)
	);

	// read address, wrapping below zero
	always_comb begin
		if (wp_q >= delay_mod) begin
			rd_ext = {1'b0, wp_q} - {1'b0, delay_mod};
		end else begin
			rd_ext = {1'b0, wp_q} + DEPTH_W - {1'b0, delay_mod};
		end
		rd = rd_ext[AW-1:0];
	end

	assign s_tready = ~ctl_s1.valid & ~mod_busy & (inflight_q < CREDITS);
	assign s_acc    = s_tvalid & s_tready;
	assign m_acc    = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			wrapped_q  <= 1'b0;
			inflight_q <= '0;
			ctl_s1     <= '0;
		end else begin
			inflight_q     <= inflight_q + CW'(s_acc) - CW'(m_acc);
			ctl_s1.valid   <= s_acc;
			ctl_s1.rd_ok   <= wrapped_q | (rd <= wp_q);
			ctl_s1.rd_same <= (delay_mod == '0);
			if (s_acc) begin
				if (wp_q == WP_LAST) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_s1    <= wp_q;
		ra_s1    <= rd;
		left_s1  <= signed'(s_tdata[15:0]);
		right_s1 <= signed'(s_tdata[31:16]);
	end

	sfd_lane #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.wr_addr_s1(wa_s1),
		.rd_addr_s1(ra_s1),
		.x_s1      (left_s1),
		.gains     (gains),
		.y_valid   (l_valid),
		.y         (l_out)
	);

	sfd_lane #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.wr_addr_s1(wa_s1),
		.rd_addr_s1(ra_s1),
		.x_s1      (right_s1),
		.gains     (gains),
		.y_valid   (r_valid),
		.y         (r_out)
	);

	sfd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.left_valid (l_valid),
		.right_valid(r_valid),
		.left       (l_out),
		.right      (r_out),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo echo. Stereo pairs go in from a queue
// through a clocked driver with random gaps. An in-bench echo predictor holds
// its own delay lines, feedback values and register copies, and works out each
// mixed pair at the input transfer. A clocked monitor with random back-pressure
// checks every output transfer against the oldest prediction. A directed
// corner part comes first, then random phases, each with new register values.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH       = sfd_pkg::BUFFER_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 8;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [15:0] left_in, [31:16] right_in
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [15:0] left_out, [31:16] right_out
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	stereo_feedback_delay_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// predictor state and register copies
	logic signed [15:0] echo_line [2][DEPTH];
	logic signed [15:0] fb_hold [2];
	int                 wr_ptr;
	int                 cfg_delay;
	int                 cfg_fb;
	int                 cfg_dry;

	logic [31:0] pending_pairs [$];
	logic [31:0] mix_expected [$];

	int  mismatches  = 0;
	int  cycle_count = 0;
	int  src_gap;
	int  sink_gap;
	bit  idle_on     = 1'b1;

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// add one half, floor-divide by 2^15
	function automatic longint q15_round(input longint p);
		return (p + 64'sd16384) >>> 15;
	endfunction

	function automatic void echo_predict(input logic [31:0] pair);
		int                 rd;
		int                 ch;
		logic signed [15:0] x;
		logic signed [15:0] delayed;
		longint             dry;
		longint             wet;
		longint             mix;
		logic [31:0]        mixed;
		dry = (cfg_dry > sfd_pkg::UNITY) ? sfd_pkg::UNITY : cfg_dry;
		wet = sfd_pkg::UNITY - dry;
		rd = (wr_ptr - (cfg_delay % DEPTH) + DEPTH) % DEPTH;
		for (ch = 0; ch < 2; ch++) begin
			x = pair[16*ch +: 16];
			// write first: a zero delay reads back the entry just written
			echo_line[ch][wr_ptr] = clip16(longint'(x) + longint'(fb_hold[ch]));
			delayed = echo_line[ch][rd];
			fb_hold[ch] = clip16(q15_round(longint'(delayed) * longint'(cfg_fb)));
			mix = longint'(x) * dry + longint'(delayed) * wet;
			mixed[16*ch +: 16] = clip16(q15_round(mix));
		end
		wr_ptr = (wr_ptr + 1) % DEPTH;
		mix_expected.push_back(mixed);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!idle_on || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 2000) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	// source side
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				echo_predict(s_tdata);
				src_gap = pick_gap();
			end
			if (src_gap != 0 || pending_pairs.size() == 0) begin
				if (src_gap != 0) src_gap--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_pairs.pop_front();
			end
		end
	end

	// sink side and checking
	always @(posedge clk) begin
		logic [31:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (mix_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output transfer: %h", m_tdata);
				end else begin
					want = mix_expected.pop_front();
					if (want[15:0] !== m_tdata[15:0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("left_out mismatch: expected %0d, got %0d",
								$signed(want[15:0]), $signed(m_tdata[15:0]));
					end
					if (want[31:16] !== m_tdata[31:16]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("right_out mismatch: expected %0d, got %0d",
								$signed(want[31:16]), $signed(m_tdata[31:16]));
					end
				end
				sink_gap = pick_gap();
			end
			if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sfd_pkg::REG_DELAY:   cfg_delay = val[15:0];
			sfd_pkg::REG_FB_GAIN: cfg_fb = val[14:0];
			sfd_pkg::REG_DRY:     cfg_dry = val[15:0];
			default: ;
		endcase
	endtask

	// hold the source until every pair is taken and every result is back
	task automatic drain();
		while (pending_pairs.size() != 0 || s_tvalid || mix_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_regs(input int dly, input int fb, input int dry);
		drain();
		reg_write(sfd_pkg::REG_DELAY, 32'(dly));
		reg_write(sfd_pkg::REG_FB_GAIN, 32'(fb));
		reg_write(sfd_pkg::REG_DRY, 32'(dry));
	endtask

	task automatic push_pair(input logic [15:0] left, input logic [15:0] right);
		pending_pairs.push_back({right, left});
	endtask

	initial begin
		int i;
		int ph;
		int n;
		int dly;
		int fb;
		int dry;
		for (i = 0; i < DEPTH; i++) begin
			echo_line[0][i] = '0;
			echo_line[1][i] = '0;
		end
		fb_hold[0] = '0;
		fb_hold[1] = '0;
		wr_ptr = 0;
		cfg_delay = sfd_pkg::DELAY_RESET;
		cfg_fb = sfd_pkg::FB_GAIN_RESET;
		cfg_dry = sfd_pkg::DRY_RESET;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of the registers
		push_pair(16'h0000, 16'h0000);
		push_pair(16'h7fff, 16'h8000);

		// zero delay, near-full feedback, wet only: write path saturates
		set_regs(0, 32767, 0);
		repeat (4) push_pair(16'h7fff, 16'h8000);
		push_pair(16'hffff, 16'h0001);
		push_pair(16'h0000, 16'h0000);

		// one-sample delay, no feedback, dry gain above unity
		set_regs(1, 0, 65535);
		push_pair(16'h8000, 16'h7fff);
		push_pair(16'h4000, 16'hc000);
		push_pair(16'h0001, 16'hffff);

		// longest delay, feedback of 32112, exact unity dry
		set_regs(65535, 32112, 32768);
		push_pair(16'h5555, 16'haaaa);
		push_pair(16'h8000, 16'h7fff);

		// short delay, half feedback, mix of both, halves in the rounding
		set_regs(2, 16384, 16384);
		push_pair(16'h7fff, 16'h7fff);
		push_pair(16'h8000, 16'h8000);
		push_pair(16'h0001, 16'hffff);
		push_pair(16'h0003, 16'hfffd);
		push_pair(16'h7fff, 16'h8000);
		push_pair(16'h0000, 16'h0000);

		for (ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 5))
				0: dly = 0;
				1: dly = $urandom_range(1, 8);
				2: dly = $urandom_range(9, 200);
				3: dly = 65535;
				4: dly = $urandom_range(1, 65535);
				default: dly = $urandom_range(1, 3);
			endcase
			case ($urandom_range(0, 4))
				0: fb = 0;
				1: fb = 32767;
				2: fb = 32112;
				default: fb = $urandom_range(0, 32767);
			endcase
			case ($urandom_range(0, 4))
				0: dry = 0;
				1: dry = sfd_pkg::UNITY;
				2: dry = 65535;
				3: dry = $urandom_range(0, sfd_pkg::UNITY);
				default: dry = $urandom_range(0, 65535);
			endcase
			set_regs(dly, fb, dry);
			idle_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(65, 75);
			for (i = 0; i < n; i++) push_pair(pick_sample(), pick_sample());
		end

		drain();
		if (mismatches == 0 && mix_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
